// File: hw/rtl/periodic_cell_neighbor_generator_macros.svh
// Assertion helpers for the RTL, used by pcng_enum. Each expects clk and rst_n in scope.
`ifndef PERIODIC_CELL_NEIGHBOR_GENERATOR_MACROS_SVH
`define PERIODIC_CELL_NEIGHBOR_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define PCNG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/pcng_pkg.sv
package pcng_pkg;

  localparam int MAX_CELLS_PER_AXIS_DEF = 32;
  localparam int MAX_SHELLS_DEF         = 3;

  localparam int CELLS_W = 6;
  localparam int SHELL_W = 2;
  localparam int COORD_W = 5;
  localparam int DZ_W    = 3;
  localparam int IDX_W   = 15;
  localparam int PLANE_W = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CELLS_W-1:0] CELLS_RST  = 6'd8;
  localparam logic [SHELL_W-1:0] SHELLS_RST = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X  = 3'd0,
    REG_CELLS_Y  = 3'd1,
    REG_CELLS_Z  = 3'd2,
    REG_SHELLS_X = 3'd3,
    REG_SHELLS_Y = 3'd4,
    REG_SHELLS_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CELLS_W-1:0] cells_x;
    logic [CELLS_W-1:0] cells_y;
    logic [CELLS_W-1:0] cells_z;
    logic [SHELL_W-1:0] shells_x;
    logic [SHELL_W-1:0] shells_y;
    logic [SHELL_W-1:0] shells_z;
    logic [PLANE_W-1:0] plane;     // cells_x * cells_y
    logic               axis_bad;  // some axis is oversized or rejects its shell count
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [IDX_W-1:0]   owner;
    logic [IDX_W-1:0]   nz;        // wrapped z layer times plane
    logic               bad;
  } item_t;

  // v mod cells by restoring subtraction; v is below 32 so five steps do.
  function automatic logic [COORD_W-1:0] axis_mod(input logic [COORD_W-1:0] v,
                                                  input logic [CELLS_W-1:0] cells);
    logic [10:0] rem;
    rem = {6'b0, v};
    for (int k = 4; k >= 0; k--) begin
      if (rem >= ({5'b0, cells} << k)) begin
        rem = rem - ({5'b0, cells} << k);
      end
    end
    return rem[COORD_W-1:0];
  endfunction

  // base + off wrapped into 0..cells-1, with |off| below cells and base below cells.
  function automatic logic [COORD_W-1:0] wrap(input logic [COORD_W-1:0] base,
                                              input logic signed [7:0] off,
                                              input logic [CELLS_W-1:0] cells);
    logic signed [7:0] s;
    logic signed [7:0] c;
    c = $signed({2'b0, cells});
    s = $signed({3'b0, base}) + off;
    if (s < 0) begin
      s = s + c;
    end else if (s >= c) begin
      s = s - c;
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

// File: hw/rtl/pcng_cfg.sv
module pcng_cfg #(
  parameter int MAX_CELLS_PER_AXIS = pcng_pkg::MAX_CELLS_PER_AXIS_DEF,
  parameter int MAX_SHELLS         = pcng_pkg::MAX_SHELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcng_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcng_pkg::CELLS_W-1:0]    cfg_data,
  output pcng_pkg::cfg_t                  cfg
);

  localparam logic [8:0] CELLS_LIM  = 9'(MAX_CELLS_PER_AXIS);
  localparam logic [2:0] SHELLS_LIM = 3'(MAX_SHELLS);

  logic [pcng_pkg::CELLS_W-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [pcng_pkg::SHELL_W-1:0] shells_x_r, shells_y_r, shells_z_r;
  logic [pcng_pkg::PLANE_W-1:0] plane_r, plane_nxt;
  logic                         axis_bad_r, axis_bad_nxt;

  function automatic logic bad_axis(input logic [pcng_pkg::CELLS_W-1:0] cells,
                                    input logic [pcng_pkg::SHELL_W-1:0] shells);
    logic [4:0] half;
    logic [4:0] need;
    half = cells[5:1];
    need = 5'(shells) + 5'd1;
    return ({3'b0, cells} > CELLS_LIM) || ({1'b0, shells} > SHELLS_LIM) || (need > half);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r  <= pcng_pkg::CELLS_RST;
      cells_y_r  <= pcng_pkg::CELLS_RST;
      cells_z_r  <= pcng_pkg::CELLS_RST;
      shells_x_r <= pcng_pkg::SHELLS_RST;
      shells_y_r <= pcng_pkg::SHELLS_RST;
      shells_z_r <= pcng_pkg::SHELLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcng_pkg::REG_CELLS_X:  cells_x_r  <= cfg_data;
        pcng_pkg::REG_CELLS_Y:  cells_y_r  <= cfg_data;
        pcng_pkg::REG_CELLS_Z:  cells_z_r  <= cfg_data;
        pcng_pkg::REG_SHELLS_X: shells_x_r <= cfg_data[pcng_pkg::SHELL_W-1:0];
        pcng_pkg::REG_SHELLS_Y: shells_y_r <= cfg_data[pcng_pkg::SHELL_W-1:0];
        pcng_pkg::REG_SHELLS_Z: shells_z_r <= cfg_data[pcng_pkg::SHELL_W-1:0];
        default: ;
      endcase
    end
  end

  // derived values are registered and update in the cycle after the registers
  always_comb begin
    plane_nxt    = 12'(cells_x_r) * 12'(cells_y_r);
    axis_bad_nxt = bad_axis(cells_x_r, shells_x_r) || bad_axis(cells_y_r, shells_y_r) ||
                   bad_axis(cells_z_r, shells_z_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r    <= 12'(pcng_pkg::CELLS_RST) * 12'(pcng_pkg::CELLS_RST);
      axis_bad_r <= 1'b0;
    end else begin
      plane_r    <= plane_nxt;
      axis_bad_r <= axis_bad_nxt;
    end
  end

  assign cfg.cells_x  = cells_x_r;
  assign cfg.cells_y  = cells_y_r;
  assign cfg.cells_z  = cells_z_r;
  assign cfg.shells_x = shells_x_r;
  assign cfg.shells_y = shells_y_r;
  assign cfg.shells_z = shells_z_r;
  assign cfg.plane    = plane_r;
  assign cfg.axis_bad = axis_bad_r;

endmodule

// File: hw/rtl/pcng_prep.sv
module pcng_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcng_pkg::cfg_t                      cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcng_pkg::COORD_W-1:0]        in_cell_x,
  input  logic [pcng_pkg::COORD_W-1:0]        in_cell_y,
  input  logic [pcng_pkg::COORD_W-1:0]        in_cell_z,
  input  logic signed [pcng_pkg::DZ_W-1:0]    in_layer_dz,
  input  logic                                take,
  output logic                                item_vld,
  output pcng_pkg::item_t                     item
);

  logic                               in_vld_r, in_vld_nxt;
  logic [pcng_pkg::COORD_W-1:0]       bx_r, by_r, bz_r;
  logic signed [pcng_pkg::DZ_W-1:0]   dz_r;
  logic                               item_vld_r, item_vld_nxt;
  pcng_pkg::item_t                    item_r, item_nxt;
  logic                               item_free, in_move, accept;
  logic signed [pcng_pkg::DZ_W-1:0]   sz;
  logic [pcng_pkg::COORD_W-1:0]       zw;
  logic [10:0]                        row_off;
  logic [16:0]                        layer_off, nz_full, owner_full;

  assign item_free = !item_vld_r || take;
  assign in_move   = in_vld_r && item_free;
  assign busy      = in_vld_r && !item_free;
  assign accept    = start && !busy;

  assign in_vld_nxt   = accept || busy;
  assign item_vld_nxt = in_move || (item_vld_r && !take);

  // stage 1: reduce coordinates into the grid
  always_ff @(posedge clk) begin
    if (accept) begin
      bx_r <= pcng_pkg::axis_mod(in_cell_x, cfg.cells_x);
      by_r <= pcng_pkg::axis_mod(in_cell_y, cfg.cells_y);
      bz_r <= pcng_pkg::axis_mod(in_cell_z, cfg.cells_z);
      dz_r <= in_layer_dz;
    end
  end

  // stage 2: owner index, layer base, range check
  always_comb begin
    sz         = $signed({1'b0, cfg.shells_z});
    zw         = pcng_pkg::wrap(bz_r, 8'(dz_r), cfg.cells_z);
    row_off    = 11'(by_r) * 11'(cfg.cells_x);
    layer_off  = 17'(bz_r) * 17'(cfg.plane);
    nz_full    = 17'(zw) * 17'(cfg.plane);
    owner_full = 17'(bx_r) + 17'(row_off) + layer_off;
    item_nxt.bx    = bx_r;
    item_nxt.by    = by_r;
    item_nxt.owner = owner_full[pcng_pkg::IDX_W-1:0];
    item_nxt.nz    = nz_full[pcng_pkg::IDX_W-1:0];
    item_nxt.bad   = cfg.axis_bad || (dz_r > sz) || (dz_r < -sz);
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      item_vld_r <= 1'b0;
    end else begin
      in_vld_r   <= in_vld_nxt;
      item_vld_r <= item_vld_nxt;
    end
  end

  assign item_vld = item_vld_r;
  assign item     = item_r;

endmodule

// File: hw/rtl/pcng_enum.sv
`include "periodic_cell_neighbor_generator_macros.svh"

module pcng_enum #(
  parameter int MAX_SHELLS = pcng_pkg::MAX_SHELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcng_pkg::cfg_t                 cfg,
  input  logic                           item_vld,
  input  pcng_pkg::item_t                item,
  output logic                           take,
  output logic                           out_valid,
  output logic [pcng_pkg::IDX_W-1:0]     out_owner_cell,
  output logic [pcng_pkg::IDX_W-1:0]     out_neighbor_cell,
  output logic                           out_last,
  output logic                           out_config_error
);

  localparam int OFF_W = $clog2(MAX_SHELLS + 1) + 1;

  logic                          run_vld_r, run_vld_nxt;
  pcng_pkg::item_t               run_r, run_nxt;
  logic signed [OFF_W-1:0]       dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [OFF_W-1:0]       sx, sy;
  logic                          run_last;
  logic [pcng_pkg::COORD_W-1:0]  nx, ny;
  logic [10:0]                   ny_off;
  logic [15:0]                   nbr_full;
  logic                          out_vld_r;
  logic [pcng_pkg::IDX_W-1:0]    out_owner_r, out_nbr_r;
  logic                          out_last_r, out_err_r;

  assign sx       = $signed(OFF_W'(cfg.shells_x));
  assign sy       = $signed(OFF_W'(cfg.shells_y));
  assign run_last = run_r.bad || ((dx_r == sx) && (dy_r == sy));
  assign take     = !run_vld_r || run_last;

  // dx inner, dy outer
  always_comb begin
    run_vld_nxt = run_vld_r;
    run_nxt     = run_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    if (take) begin
      run_vld_nxt = item_vld;
      if (item_vld) begin
        run_nxt = item;
        dx_nxt  = -sx;
        dy_nxt  = -sy;
      end
    end else if (dx_r == sx) begin
      dx_nxt = -sx;
      dy_nxt = dy_r + OFF_W'(1);
    end else begin
      dx_nxt = dx_r + OFF_W'(1);
    end
  end

  always_comb begin
    nx       = pcng_pkg::wrap(run_r.bx, 8'(dx_r), cfg.cells_x);
    ny       = pcng_pkg::wrap(run_r.by, 8'(dy_r), cfg.cells_y);
    ny_off   = 11'(ny) * 11'(cfg.cells_x);
    nbr_full = 16'(nx) + 16'(ny_off) + 16'(run_r.nz);
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    if (run_r.bad) begin
      out_owner_r <= '0;
      out_nbr_r   <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end else begin
      out_owner_r <= run_r.owner;
      out_nbr_r   <= nbr_full[pcng_pkg::IDX_W-1:0];
      out_last_r  <= run_last;
      out_err_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      run_vld_r <= run_vld_nxt;
      out_vld_r <= run_vld_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_owner_cell    = out_owner_r;
  assign out_neighbor_cell = out_nbr_r;
  assign out_last          = out_last_r;
  assign out_config_error  = out_err_r;

  `PCNG_ASSERT_NOW(a_err_is_last, out_vld_r && out_err_r, out_last_r, "error word not last")
  `PCNG_ASSERT_NEXT(a_run_continues, out_vld_r && !out_last_r, out_vld_r, "run broke off early")
  `PCNG_ASSERT_NEXT(a_owner_steady, out_vld_r && !out_last_r,
                    out_owner_r == $past(out_owner_r), "owner changed within a run")
  `PCNG_ASSERT_NEXT(a_item_held, item_vld && !take, item_vld, "pending item dropped")

endmodule

// File: hw/rtl/periodic_cell_neighbor_generator.sv
// Periodic 3-D cell-list neighbor generator.
// Config channel: cfg_valid/cfg_ready with cfg_index (0..5: cells x/y/z,
//   shells x/y/z) and cfg_data; always ready. Write only while idle.
// Input channel: a word is taken when start is high and busy is low. It names
//   the owning cell (in_cell_x/y/z) and one z layer offset (in_layer_dz).
// Results: each word is on out_* for one cycle, flagged by out_valid. Per input
//   the block walks dy over -shells_y..+shells_y and, inside it, dx over
//   -shells_x..+shells_x, giving (2*shells_x+1)*(2*shells_y+1) words, the final
//   one with out_last. Issue one input per dz for the full neighborhood.
// Rejected input (axis above MAX_CELLS_PER_AXIS, shells above MAX_SHELLS or
//   too many for the axis, or offset outside +-shells_z): one word with
//   out_config_error and out_last set, indices zero.
// Pipeline: the accepting edge loads the reduced coordinates, then come the
//   index/layer stage, the walker and the output register.
// Throughput: the walker emits one word per cycle while it has a run.
//   Two inputs queue in the front stages behind the walker; once they fill,
//   busy follows the walker, which starts the next run right after a last word.
// Reset (rst_n low, synchronous): grid 8x8x8, one shell per axis, pipeline
//   empty. The receiver cannot stall; words are never held.
module periodic_cell_neighbor_generator #(
  parameter int MAX_CELLS_PER_AXIS = pcng_pkg::MAX_CELLS_PER_AXIS_DEF,
  parameter int MAX_SHELLS         = pcng_pkg::MAX_SHELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcng_pkg::CELLS_W-1:0]       cfg_data,
  // input command
  input  logic                               start,
  output logic                               busy,
  input  logic [pcng_pkg::COORD_W-1:0]       in_cell_x,
  input  logic [pcng_pkg::COORD_W-1:0]       in_cell_y,
  input  logic [pcng_pkg::COORD_W-1:0]       in_cell_z,
  input  logic signed [pcng_pkg::DZ_W-1:0]   in_layer_dz,
  // result strobe
  output logic                               out_valid,
  output logic [pcng_pkg::IDX_W-1:0]         out_owner_cell,
  output logic [pcng_pkg::IDX_W-1:0]         out_neighbor_cell,
  output logic                               out_last,
  output logic                               out_config_error
);

  pcng_pkg::cfg_t  cfg;     // live config plus derived plane size / reject flag
  pcng_pkg::item_t item;    // prepared item waiting for the walker
  logic            item_vld;
  logic            take;    // walker loads the pending item this cycle

  pcng_cfg #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .MAX_SHELLS         (MAX_SHELLS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // two-stage front end: mod reduction, then owner index and layer base
  pcng_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_cell_z   (in_cell_z),
    .in_layer_dz (in_layer_dz),
    .take        (take),
    .item_vld    (item_vld),
    .item        (item)
  );

  // dx/dy walker, one neighbor index per cycle into the output register
  pcng_enum #(
    .MAX_SHELLS (MAX_SHELLS)
  ) u_enum (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .item_vld          (item_vld),
    .item              (item),
    .take              (take),
    .out_valid         (out_valid),
    .out_owner_cell    (out_owner_cell),
    .out_neighbor_cell (out_neighbor_cell),
    .out_last          (out_last),
    .out_config_error  (out_config_error)
  );

endmodule

// File: test/testbench.sv
module testbench;
  import pcng_pkg::*;

  // Register indexes the block does not decode; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int MAX_CELLS = 32;
  localparam int MAX_SH = 3;
  localparam int MAX_REPORTED = 10;
  localparam int SETTLE_CYCLES = 8;

  // One layer request: owning cell plus the z offset of the layer to walk.
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [DZ_W-1:0]    dz;
  } layer_req_t;

  // One predicted neighbor word, tagged with the cycle its request was taken.
  typedef struct {
    logic [IDX_W-1:0] owner;
    logic [IDX_W-1:0] neighbor;
    logic             last;
    logic             cfg_err;
    int               taken_at;
  } neighbor_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_CELLS_X;
  logic [CELLS_W-1:0]     cfg_data = '0;

  logic                   start = 1'b0;
  logic                   busy;
  logic [COORD_W-1:0]     in_cell_x = '0;
  logic [COORD_W-1:0]     in_cell_y = '0;
  logic [COORD_W-1:0]     in_cell_z = '0;
  logic signed [DZ_W-1:0] in_layer_dz = '0;

  logic                   out_valid;
  logic [IDX_W-1:0]       out_owner_cell;
  logic [IDX_W-1:0]       out_neighbor_cell;
  logic                   out_last;
  logic                   out_config_error;

  periodic_cell_neighbor_generator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .start             (start),
    .busy              (busy),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_cell_z         (in_cell_z),
    .in_layer_dz       (in_layer_dz),
    .out_valid         (out_valid),
    .out_owner_cell    (out_owner_cell),
    .out_neighbor_cell (out_neighbor_cell),
    .out_last          (out_last),
    .out_config_error  (out_config_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the grid registers, updated when a write handshakes.
  int grid_nx = CELLS_RST;
  int grid_ny = CELLS_RST;
  int grid_nz = CELLS_RST;
  int shell_x = SHELLS_RST;
  int shell_y = SHELLS_RST;
  int shell_z = SHELLS_RST;

  layer_req_t     layer_reqs_pending[$];  // filled by the stimulus, drained by the driver
  neighbor_word_t expected_neighbors[$];  // predicted words, oldest first
  layer_req_t     on_port;                // request currently presented on in_*

  int cyc = 0;
  int sender_idle_pct = 0;
  int n_failures = 0;
  int n_taken = 0;
  int n_words_checked = 0;
  int n_grids = 1;

  // Free-running cycle count; read by driver and monitor before it moves, so a
  // word can only be matched against requests taken at an earlier edge.
  always @(posedge clk) cyc <= cyc + 1;

  // An axis is rejected when the grid is oversized, the shells exceed MAX_SH,
  // or the shells wrap onto themselves (shells + 1 above half the cell count).
  function automatic bit axis_rejected(input int cells, input int shells);
    return (cells > MAX_CELLS) || (shells > MAX_SH) || (shells + 1 > cells / 2);
  endfunction

  function automatic int wrap_axis(input int coord, input int off, input int cells);
    return ((coord % cells) + cells + off) % cells;
  endfunction

  // Predicts every word one layer request produces: dy outer, dx inner.
  function automatic void enumerate_layer(input layer_req_t r, input int taken_at);
    int dz, plane, owner, nz, ny, nx;
    bit rejected;
    neighbor_word_t w;
    dz = r.dz[DZ_W-1] ? int'(r.dz) - (1 << DZ_W) : int'(r.dz);
    rejected = axis_rejected(grid_nx, shell_x) || axis_rejected(grid_ny, shell_y) ||
               axis_rejected(grid_nz, shell_z) || dz < -shell_z || dz > shell_z;
    w.taken_at = taken_at;
    if (rejected) begin
      w.owner = '0;
      w.neighbor = '0;
      w.last = 1'b1;
      w.cfg_err = 1'b1;
      expected_neighbors.push_back(w);
      return;
    end
    plane = grid_nx * grid_ny;
    owner = int'(r.x) % grid_nx + (int'(r.y) % grid_ny) * grid_nx +
            (int'(r.z) % grid_nz) * plane;
    nz = wrap_axis(int'(r.z), dz, grid_nz) * plane;
    w.cfg_err = 1'b0;
    w.owner = owner[IDX_W-1:0];
    for (int dy = -shell_y; dy <= shell_y; dy++) begin
      ny = wrap_axis(int'(r.y), dy, grid_ny) * grid_nx;
      for (int dx = -shell_x; dx <= shell_x; dx++) begin
        nx = wrap_axis(int'(r.x), dx, grid_nx);
        w.neighbor = IDX_W'(nx + ny + nz);
        w.last = (dy == shell_y) && (dx == shell_x);
        expected_neighbors.push_back(w);
      end
    end
  endfunction

  function automatic void note_failure(input string what);
    n_failures++;
    if (n_failures <= MAX_REPORTED) $display("MISMATCH at cycle %0d: %s", cyc, what);
  endfunction

  // Driver: holds start until the block takes the word, then either presents
  // the next pending request or idles, as the current idle rate decides.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        enumerate_layer(on_port, cyc);
        n_taken++;
      end
      if (start && busy) begin
        // keep presenting the same word
      end else if (layer_reqs_pending.size() != 0 &&
                   $urandom_range(99, 0) >= sender_idle_pct) begin
        on_port = layer_reqs_pending.pop_front();
        start       <= 1'b1;
        in_cell_x   <= on_port.x;
        in_cell_y   <= on_port.y;
        in_cell_z   <= on_port.z;
        in_layer_dz <= on_port.dz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word must match the oldest prediction.
  always @(posedge clk) begin : monitor
    neighbor_word_t want;
    if (rst_n && out_valid) begin
      if (expected_neighbors.size() == 0 || expected_neighbors[0].taken_at >= cyc) begin
        note_failure($sformatf("unexpected word owner %0d neighbor %0d last %0b err %0b",
                               out_owner_cell, out_neighbor_cell, out_last,
                               out_config_error));
      end else begin
        want = expected_neighbors.pop_front();
        n_words_checked++;
        if (out_owner_cell !== want.owner || out_neighbor_cell !== want.neighbor ||
            out_last !== want.last || out_config_error !== want.cfg_err) begin
          note_failure($sformatf(
            "expected owner %0d neighbor %0d last %0b err %0b, got %0d %0d %0b %0b",
            want.owner, want.neighbor, want.last, want.cfg_err,
            out_owner_cell, out_neighbor_cell, out_last, out_config_error));
        end
      end
    end
  end

  // One register write over the config channel; the shadow copy follows it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CELLS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CELLS_X:  grid_nx = int'(value[CELLS_W-1:0]);
      REG_CELLS_Y:  grid_ny = int'(value[CELLS_W-1:0]);
      REG_CELLS_Z:  grid_nz = int'(value[CELLS_W-1:0]);
      REG_SHELLS_X: shell_x = int'(value[SHELL_W-1:0]);
      REG_SHELLS_Y: shell_y = int'(value[SHELL_W-1:0]);
      REG_SHELLS_Z: shell_z = int'(value[SHELL_W-1:0]);
      default: ;  // undecoded index, ignored
    endcase
  endtask

  task automatic set_grid(input int nx, input int ny, input int nz,
                          input int sx, input int sy, input int sz);
    write_reg(REG_CELLS_X, nx);
    write_reg(REG_CELLS_Y, ny);
    write_reg(REG_CELLS_Z, nz);
    write_reg(REG_SHELLS_X, sx);
    write_reg(REG_SHELLS_Y, sy);
    write_reg(REG_SHELLS_Z, sz);
    n_grids++;
  endtask

  // Wait until the sender is empty and every predicted word has come back,
  // then let the pipeline settle before touching the registers.
  task automatic drain_block();
    @(negedge clk);
    while (layer_reqs_pending.size() != 0 || start || expected_neighbors.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Idle rate rotates per phase: none, sender 46%, receiver-only (no effect
  // here, the receiver cannot stall), both at 28%.
  task automatic begin_phase(input int phase);
    int idle_rates[4];
    idle_rates = '{0, 46, 0, 28};
    @(negedge clk);
    sender_idle_pct = idle_rates[phase % 4];
  endtask

  task automatic push_req(input int x, input int y, input int z, input int dz);
    layer_req_t r;
    r.x = x[COORD_W-1:0];
    r.y = y[COORD_W-1:0];
    r.z = z[COORD_W-1:0];
    r.dz = dz[DZ_W-1:0];
    layer_reqs_pending.push_back(r);
  endtask

  // Mostly in-range coordinates, sometimes the full 5-bit range.
  function automatic int rand_coord(input int cells);
    if (cells >= 1 && cells <= MAX_CELLS && $urandom_range(4, 0) != 0)
      return $urandom_range(cells - 1, 0);
    return $urandom_range(31, 0);
  endfunction

  function automatic int rand_dz();
    if ($urandom_range(4, 0) != 0) return int'($urandom_range(2 * shell_z, 0)) - shell_z;
    return $urandom_range(7, 0);
  endfunction

  // Mostly legal grids (shells fit the cell count); now and then raw register
  // values, which include oversized and degenerate axes.
  function automatic int rand_cells();
    if ($urandom_range(11, 0) == 0) return $urandom_range(63, 0);
    return $urandom_range(MAX_CELLS, 4);
  endfunction

  function automatic int rand_shells(input int cells);
    int top;
    if ($urandom_range(11, 0) == 0) return $urandom_range(3, 0);
    top = cells / 2 - 1;
    if (top > MAX_SH) top = MAX_SH;
    if (top < 0) top = 0;
    return $urandom_range(top, 0);
  endfunction

  initial begin : stimulus
    int nx, ny, nz;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset grid 8x8x8, one shell: wrap at both ends, coordinates above the
    // cell count, and offsets outside the shell range including -4 and +3.
    begin_phase(0);
    push_req(0, 0, 0, -1);
    push_req(0, 0, 0, 0);
    push_req(0, 0, 0, 1);
    push_req(7, 7, 7, 1);
    push_req(31, 31, 31, 0);
    push_req(3, 5, 2, -4);
    push_req(3, 5, 2, 3);
    push_req(2, 2, 2, -2);
    // Sender holds off here until every word of the first burst is back.
    drain_block();

    // Largest grid and shells: 49 words per legal request, widest indices.
    set_grid(32, 32, 32, 3, 3, 3);
    begin_phase(1);
    push_req(0, 0, 0, -3);
    push_req(31, 31, 31, 3);
    push_req(31, 0, 16, -4);
    drain_block();

    // Smallest grid that still takes one shell.
    set_grid(4, 4, 4, 1, 1, 1);
    begin_phase(2);
    push_req(3, 0, 3, 1);
    push_req(31, 17, 4, -1);
    drain_block();

    // Zero shells on tiny axes: one word per request, only dz 0 allowed.
    set_grid(2, 3, 5, 0, 0, 0);
    begin_phase(3);
    push_req(1, 2, 4, 0);
    push_req(0, 0, 0, 1);
    push_req(31, 31, 31, 0);
    drain_block();

    // Oversized and empty axes: everything rejected.
    set_grid(63, 0, 33, 3, 3, 3);
    begin_phase(4);
    push_req(0, 0, 0, 0);
    push_req(5, 5, 5, 0);
    drain_block();

    // Uneven shells, then writes to undecoded indexes that must not land.
    set_grid(8, 8, 8, 3, 1, 2);
    write_reg(REG_SPARE_A, 1);
    write_reg(REG_SPARE_B, 0);
    begin_phase(5);
    push_req(0, 7, 0, -2);
    push_req(7, 0, 7, 2);
    drain_block();

    // Shells exactly at the limit on x and y, none on z.
    set_grid(6, 8, 7, 2, 3, 0);
    begin_phase(6);
    push_req(5, 0, 6, 0);
    push_req(0, 7, 0, 1);
    drain_block();

    // Shells one too many for an odd axis.
    set_grid(7, 16, 16, 3, 1, 1);
    begin_phase(7);
    push_req(1, 1, 1, 0);
    drain_block();

    // Random grids, each with a burst of random layer requests.
    for (int phase = 8; phase < 14; phase++) begin
      nx = rand_cells();
      ny = rand_cells();
      nz = rand_cells();
      set_grid(nx, ny, nz, rand_shells(nx), rand_shells(ny), rand_shells(nz));
      begin_phase(phase);
      for (int k = 0; k < 15; k++)
        push_req(rand_coord(grid_nx), rand_coord(grid_ny), rand_coord(grid_nz), rand_dz());
      drain_block();
    end

    $display("Ran %0d layer requests over %0d grid settings; %0d neighbor words checked,",
             n_taken, n_grids, n_words_checked);
    $display("%0d mismatches (wrap, rejection, zero-shell and register decode cases).",
             n_failures);
    if (n_failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
